// ===== design/c2sv_pkg.sv =====
// shared types and constants for the cartesian to spherical velocity pipeline
// no dependencies
package c2sv_pkg;

  localparam int ANGLE_ITERATIONS = 24;
  localparam int POS_SHIFT        = 24;
  localparam int VEL_GUARD        = 4;
  localparam int DW               = 64;
  localparam int ITER_W           = $clog2(ANGLE_ITERATIONS);
  localparam logic [31:0] INV_GAIN = 32'h9B74EDA8;
  localparam int LATENCY          = 2 + 2 * (ANGLE_ITERATIONS + 4);

  typedef enum logic [0:0] {
    REG_DIM   = 1'b0,
    REG_SCALE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] speed_radial;
    logic signed [63:0] speed_azimuth;
    logic signed [63:0] speed_polar;
  } out_item_t;

  typedef struct packed {
    logic                 vld;
    logic                 skip;
    logic                 dim;
    logic signed [DW-1:0] a;
    logic signed [DW-1:0] b;
    logic signed [DW-1:0] u;
    logic signed [DW-1:0] w;
    logic signed [DW-1:0] c;
  } pass_t;

endpackage

// ===== design/cartesian_to_spherical_velocity.sv =====
// top level: register port, velocity scaling, two vectoring passes, rounding
// depends on c2sv_pkg, c2sv_pass
//
// channel  | ports                         | handshake
// input    | start, busy, in_data          | taken when start and not busy
// result   | out_valid, out_data           | one-cycle strobe, no back-pressure
// config   | psel penable pwrite paddr ... | apb read and write, pready tied high
//
// one item per cycle; each result passes the input register, both passes and the output register
// each pass is 1 fold stage, 24 micro-rotation stages and 3 gain stages
// busy stays low; reset clears the valid bits and sets the dim and scale registers to 1
// the receiver cannot stall, so the pipeline advances every cycle
module cartesian_to_spherical_velocity import c2sv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_data,
  output logic        out_valid,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        dim_r;
  logic [24:0] scale_r;
  reg_idx_t    ridx;
  logic        wr_en;
  pass_t       sc_r;
  pass_t       p1_out, p2_in, p2_out;
  logic signed [56:0]   vx_m, vy_m, vz_m;
  logic signed [DW-1:0] vx_p, vy_p, vz_p;
  logic signed [DW-1:0] rad_nxt, azi_nxt, pol_nxt;
  logic        out_valid_r;
  out_item_t   out_data_r;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign ridx   = reg_idx_t'(paddr[2]);
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r   <= 1'b1;
      scale_r <= 25'd1;
    end else if (wr_en) begin
      unique case (ridx)
        REG_DIM:   dim_r   <= pwdata[0];
        REG_SCALE: scale_r <= pwdata[24:0];
        default:   dim_r   <= dim_r;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_DIM:   prdata = {31'd0, dim_r};
      REG_SCALE: prdata = {7'd0, scale_r};
      default:   prdata = '0;
    endcase
  end

  always_comb begin
    vx_m = in_data.vel_x * $signed({1'b0, scale_r});
    vy_m = in_data.vel_y * $signed({1'b0, scale_r});
    vz_m = in_data.vel_z * $signed({1'b0, scale_r});
    vx_p = DW'(vx_m) <<< VEL_GUARD;
    vy_p = DW'(vy_m) <<< VEL_GUARD;
    vz_p = DW'(vz_m) <<< VEL_GUARD;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r.vld <= 1'b0;
    end else begin
      sc_r.vld <= start;
    end
  end

  always_ff @(posedge clk) begin
    sc_r.skip <= 1'b0;
    sc_r.dim  <= dim_r;
    sc_r.a    <= DW'(in_data.pos_x) <<< POS_SHIFT;
    sc_r.b    <= DW'(in_data.pos_y) <<< POS_SHIFT;
    sc_r.u    <= vx_p;
    sc_r.w    <= vy_p;
    sc_r.c    <= DW'(in_data.pos_z) <<< POS_SHIFT;
  end

  c2sv_pass u_pass1 (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (sc_r),
    .out_s (p1_out)
  );

  // vz has no slot in the first pass, whose slots carry x, y, vx, vy and z;
  // so it is carried separately by a delay line below
  logic signed [DW-1:0] vz_line [ANGLE_ITERATIONS+5];
  always_ff @(posedge clk) begin
    vz_line[0] <= vz_p;
    for (int k = 1; k < ANGLE_ITERATIONS + 5; k++) begin
      vz_line[k] <= vz_line[k-1];
    end
  end

  always_comb begin
    p2_in      = p1_out;
    p2_in.skip = ~p1_out.dim;
    p2_in.a    = p1_out.c;
    p2_in.b    = p1_out.a;
    p2_in.u    = vz_line[ANGLE_ITERATIONS+4];
    p2_in.w    = p1_out.u;
    p2_in.c    = p1_out.w;
  end

  c2sv_pass u_pass2 (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (p2_in),
    .out_s (p2_out)
  );

  always_comb begin
    if (p2_out.dim) begin
      rad_nxt = (p2_out.u + DW'(1 <<< (VEL_GUARD - 1))) >>> VEL_GUARD;
      pol_nxt = (p2_out.w + DW'(1 <<< (VEL_GUARD - 1))) >>> VEL_GUARD;
    end else begin
      rad_nxt = (p2_out.w + DW'(1 <<< (VEL_GUARD - 1))) >>> VEL_GUARD;
      pol_nxt = '0;
    end
    azi_nxt = (p2_out.c + DW'(1 <<< (VEL_GUARD - 1))) >>> VEL_GUARD;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= p2_out.vld;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r.speed_radial  <= rad_nxt;
    out_data_r.speed_azimuth <= azi_nxt;
    out_data_r.speed_polar   <= pol_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/c2sv_iter.sv =====
// one registered micro-rotation of the vectoring pass
// depends on c2sv_pkg
module c2sv_iter import c2sv_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [ITER_W-1:0] shift,
  input  pass_t             in_s,
  output pass_t             out_s
);

  pass_t nxt;
  pass_t st_r;
  logic signed [DW-1:0] sa, sb, su, sw;

  always_comb begin
    sa = in_s.a >>> shift;
    sb = in_s.b >>> shift;
    su = in_s.u >>> shift;
    sw = in_s.w >>> shift;
    nxt = in_s;
    if (!in_s.skip) begin
      if (!in_s.b[DW-1]) begin
        nxt.a = in_s.a + sb;
        nxt.b = in_s.b - sa;
        nxt.u = in_s.u + sw;
        nxt.w = in_s.w - su;
      end else begin
        nxt.a = in_s.a - sb;
        nxt.b = in_s.b + sa;
        nxt.u = in_s.u - sw;
        nxt.w = in_s.w + su;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.vld <= 1'b0;
    end else begin
      st_r.vld <= in_s.vld;
    end
  end

  always_ff @(posedge clk) begin
    st_r.skip <= nxt.skip;
    st_r.dim  <= nxt.dim;
    st_r.a    <= nxt.a;
    st_r.b    <= nxt.b;
    st_r.u    <= nxt.u;
    st_r.w    <= nxt.w;
    st_r.c    <= nxt.c;
  end

  assign out_s = st_r;

endmodule

// ===== design/c2sv_gain.sv =====
// three-stage gain compensation of a, u and w, rounded half away from zero
// depends on c2sv_pkg
module c2sv_gain import c2sv_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  pass_t in_s,
  output pass_t out_s
);

  pass_t s1_r, s2_r, s3_r;
  logic [DW-1:0] mag_nxt [3];
  logic [DW-1:0] mag_r [3];
  logic          neg_r [3];
  logic          neg2_r [3];
  logic [DW-1:0] hi_r [3];
  logic [DW-1:0] lo_r [3];
  logic [DW-1:0] res [3];
  logic [DW-1:0] rnd [3];
  logic signed [DW-1:0] val [3];
  pass_t nxt;

  always_comb begin
    val[0] = in_s.a;
    val[1] = in_s.u;
    val[2] = in_s.w;
    for (int k = 0; k < 3; k++) begin
      mag_nxt[k] = val[k][DW-1] ? DW'(-val[k]) : DW'(val[k]);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rnd[k] = hi_r[k] + ((lo_r[k] + 64'h8000_0000) >> 32);
      res[k] = neg2_r[k] ? DW'(-rnd[k]) : rnd[k];
    end
    nxt = s2_r;
    if (!s2_r.skip) begin
      nxt.a = signed'(res[0]);
      nxt.b = '0;
      nxt.u = signed'(res[1]);
      nxt.w = signed'(res[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
      s2_r.vld <= 1'b0;
      s3_r.vld <= 1'b0;
    end else begin
      s1_r.vld <= in_s.vld;
      s2_r.vld <= s1_r.vld;
      s3_r.vld <= s2_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_r.skip <= in_s.skip;
    s1_r.dim  <= in_s.dim;
    s1_r.a    <= in_s.a;
    s1_r.b    <= in_s.b;
    s1_r.u    <= in_s.u;
    s1_r.w    <= in_s.w;
    s1_r.c    <= in_s.c;
    s2_r.skip <= s1_r.skip;
    s2_r.dim  <= s1_r.dim;
    s2_r.a    <= s1_r.a;
    s2_r.b    <= s1_r.b;
    s2_r.u    <= s1_r.u;
    s2_r.w    <= s1_r.w;
    s2_r.c    <= s1_r.c;
    s3_r.skip <= nxt.skip;
    s3_r.dim  <= nxt.dim;
    s3_r.a    <= nxt.a;
    s3_r.b    <= nxt.b;
    s3_r.u    <= nxt.u;
    s3_r.w    <= nxt.w;
    s3_r.c    <= nxt.c;
    for (int k = 0; k < 3; k++) begin
      mag_r[k]  <= mag_nxt[k];
      neg_r[k]  <= val[k][DW-1];
      neg2_r[k] <= neg_r[k];
      hi_r[k]   <= mag_r[k][63:32] * INV_GAIN;
      lo_r[k]   <= mag_r[k][31:0] * INV_GAIN;
    end
  end

  assign out_s = s3_r;

endmodule

// ===== design/c2sv_pass.sv =====
// one vectoring pass: half-plane fold, micro-rotation chain, gain compensation
// depends on c2sv_pkg, c2sv_iter, c2sv_gain
module c2sv_pass import c2sv_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  pass_t in_s,
  output pass_t out_s
);

  pass_t nxt;
  pass_t pre_r;
  pass_t chain [ANGLE_ITERATIONS+1];

  always_comb begin
    nxt = in_s;
    nxt.skip = in_s.skip | ((in_s.a == '0) && (in_s.b == '0));
    if (!nxt.skip && in_s.a[DW-1]) begin
      nxt.a = -in_s.a;
      nxt.b = -in_s.b;
      nxt.u = -in_s.u;
      nxt.w = -in_s.w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_r.vld <= 1'b0;
    end else begin
      pre_r.vld <= in_s.vld;
    end
  end

  always_ff @(posedge clk) begin
    pre_r.skip <= nxt.skip;
    pre_r.dim  <= nxt.dim;
    pre_r.a    <= nxt.a;
    pre_r.b    <= nxt.b;
    pre_r.u    <= nxt.u;
    pre_r.w    <= nxt.w;
    pre_r.c    <= nxt.c;
  end

  assign chain[0] = pre_r;

  for (genvar i = 0; i < ANGLE_ITERATIONS; i++) begin : g_iter
    c2sv_iter u_iter (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (ITER_W'(i)),
      .in_s  (chain[i]),
      .out_s (chain[i+1])
    );
  end

  c2sv_gain u_gain (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (chain[ANGLE_ITERATIONS]),
    .out_s (out_s)
  );

endmodule

// ===== design/c2sv_checker.sv =====
// port-level checks for the top level, attached by bind
// depends on c2sv_pkg and cartesian_to_spherical_velocity
module c2sv_checker import c2sv_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic pready
);

  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LATENCY out_valid)
    else $error("item without result");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    !start |-> ##LATENCY !out_valid)
    else $error("result without item");

endmodule

bind cartesian_to_spherical_velocity c2sv_checker u_c2sv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .pready    (pready)
);

// ===== tb/testbench.sv =====
// testbench for cartesian_to_spherical_velocity: directed and random points,
// register writes over the apb port, results checked against a cordic predictor
// depends on c2sv_pkg and the design files
`timescale 1ns / 1ps

module testbench;
  import c2sv_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_data;
  logic        out_valid;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic        mode_3d;
  logic [24:0] vel_factor;
  out_item_t   pending_speeds[$];
  int          fail_count = 0;
  int          idle_cycles = 0;

  cartesian_to_spherical_velocity i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [63:0] shr(logic signed [63:0] v, int s);
    return v >>> s;
  endfunction

  function automatic logic signed [63:0] gain_comp(logic signed [63:0] a);
    logic [63:0]  m;
    logic [127:0] r;
    m = a[63] ? -a : a;
    r = {96'd0, m[63:32]} * INV_GAIN + ((({96'd0, m[31:0]} * INV_GAIN) + 128'h80000000) >> 32);
    return a[63] ? -r[63:0] : r[63:0];
  endfunction

  task automatic rotate_onto_axis(inout logic signed [63:0] pa, inout logic signed [63:0] pb,
                                  inout logic signed [63:0] va, inout logic signed [63:0] vb);
    logic signed [63:0] a, b, u, w, na, nb, nu, nw;
    if (pa == 0 && pb == 0) return;
    a = pa; b = pb; u = va; w = vb;
    if (a < 0) begin
      a = -a; b = -b; u = -u; w = -w;
    end
    for (int i = 0; i < ANGLE_ITERATIONS; i++) begin
      if (b >= 0) begin
        na = a + shr(b, i); nb = b - shr(a, i);
        nu = u + shr(w, i); nw = w - shr(u, i);
      end else begin
        na = a - shr(b, i); nb = b + shr(a, i);
        nu = u - shr(w, i); nw = w + shr(u, i);
      end
      a = na; b = nb; u = nu; w = nw;
    end
    pa = gain_comp(a);
    pb = 0;
    va = gain_comp(u);
    vb = gain_comp(w);
  endtask

  function automatic logic signed [63:0] drop_guard(logic signed [63:0] v);
    return (v + (64'sd1 <<< (VEL_GUARD - 1))) >>> VEL_GUARD;
  endfunction

  task automatic predict_speeds(input in_item_t it);
    logic signed [63:0] x, y, z, vx, vy, vz, vs;
    out_item_t r;
    vs = $signed({39'd0, vel_factor}) <<< VEL_GUARD;
    x = 64'(it.pos_x) <<< POS_SHIFT;
    y = 64'(it.pos_y) <<< POS_SHIFT;
    z = 64'(it.pos_z) <<< POS_SHIFT;
    vx = 64'(it.vel_x) * vs;
    vy = 64'(it.vel_y) * vs;
    vz = 64'(it.vel_z) * vs;
    rotate_onto_axis(x, y, vx, vy);
    if (!mode_3d) begin
      r.speed_radial = drop_guard(vx);
      r.speed_azimuth = drop_guard(vy);
      r.speed_polar = '0;
    end else begin
      rotate_onto_axis(z, x, vz, vx);
      r.speed_radial = drop_guard(vz);
      r.speed_azimuth = drop_guard(vy);
      r.speed_polar = drop_guard(vx);
    end
    pending_speeds.push_back(r);
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid) begin
      if (pending_speeds.size() == 0) begin
        $error("unexpected result %h", out_data);
        fail_count++;
      end else begin
        e = pending_speeds.pop_front();
        if (out_data.speed_radial !== e.speed_radial) begin
          $error("speed_radial exp %0d got %0d", e.speed_radial, out_data.speed_radial);
          fail_count++;
        end
        if (out_data.speed_azimuth !== e.speed_azimuth) begin
          $error("speed_azimuth exp %0d got %0d", e.speed_azimuth, out_data.speed_azimuth);
          fail_count++;
        end
        if (out_data.speed_polar !== e.speed_polar) begin
          $error("speed_polar exp %0d got %0d", e.speed_polar, out_data.speed_polar);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (psel && penable)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_point(input in_item_t it);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_speeds(it);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_speeds.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'(4 * idx); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_DIM) mode_3d = val[0];
    else vel_factor = val[24:0];
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return '0;
      3: return 32'($signed($urandom_range(0, 200)) - 100);
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t rand_point();
    in_item_t it;
    it = {rand_word(), rand_word(), rand_word(), rand_word(), rand_word(), rand_word()};
    if ($urandom_range(0, 9) == 0) begin
      it.pos_x = '0; it.pos_y = '0;
      if ($urandom_range(0, 1) == 0) it.pos_z = '0;
    end
    return it;
  endfunction

  task automatic test_directed;
    logic [31:0] ext[4] = '{32'h80000000, 32'h7fffffff, 32'h0, 32'hffffffff};
    send_point('{default: '0});
    send_point('{pos_x: 0, pos_y: 0, pos_z: 5, vel_x: 32'h10000, vel_y: -3, vel_z: 7});
    send_point('{pos_x: -7, pos_y: 3, pos_z: -2, vel_x: 11, vel_y: 32'h20000, vel_z: -9});
    send_point('{pos_x: 4, pos_y: -9, pos_z: 0, vel_x: -1, vel_y: 1, vel_z: 1});
    for (int i = 0; i < 4; i++)
      send_point('{ext[i], ext[3 - i], ext[i], ext[3 - i], ext[i], ext[(i + 1) % 4]});
    drain();
  endtask

  task automatic test_random(input int n);
    repeat (n) send_point(rand_point());
    drain();
  endtask

  task automatic test_2d_mode;
    write_reg(REG_DIM, 32'h0);
    send_point('{default: '0});
    send_point('{pos_x: -5, pos_y: 0, pos_z: 9, vel_x: 3, vel_y: 4, vel_z: 5});
    test_random(150);
  endtask

  task automatic test_scale;
    write_reg(REG_SCALE, 32'hffffffff);
    test_random(100);
    write_reg(REG_DIM, 32'hfffffffe);
    test_random(100);
    write_reg(REG_SCALE, 32'h0);
    test_random(20);
    write_reg(REG_SCALE, 32'd31557600);
    write_reg(REG_DIM, 32'h1);
    test_random(100);
    write_reg(REG_SCALE, 32'h1);
  endtask

  initial begin
    mode_3d = 1'b1;
    vel_factor = 25'd1;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(250);
    test_2d_mode();
    test_scale();
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
design/c2sv_pkg.sv
design/c2sv_iter.sv
design/c2sv_gain.sv
design/c2sv_pass.sv
design/cartesian_to_spherical_velocity.sv
design/c2sv_checker.sv
tb/testbench.sv
